// File: hdl/pfs_pkg.sv
// ============================================================================
// pfs_pkg: shared types and constants of the prologue frame size scanner
// Instruction encodings, class codes, field widths and the structs that
// travel between the decoder, the frame state unit and the top level.
// ============================================================================
package pfs_pkg;

    // Field widths
    localparam int UNITS_W  = 27;
    localparam int LIMIT_W  = 30;
    localparam int ACC_W    = 31;
    localparam int AMT_W    = 13;
    localparam int RP_W     = 5;
    localparam int CLS_W    = 3;
    localparam int WORD_W   = 32;

    // Request types
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_INSN  = 1'b1;

    // Instruction classes reported per item
    localparam logic [CLS_W-1:0] CLS_NONE   = 3'd0;
    localparam logic [CLS_W-1:0] CLS_ALLOC  = 3'd1;  // ldo / stwm
    localparam logic [CLS_W-1:0] CLS_STD_MA = 3'd2;  // std,ma
    localparam logic [CLS_W-1:0] CLS_STW_RP = 3'd3;  // stw rp,-20(sp)
    localparam logic [CLS_W-1:0] CLS_STD_RP = 3'd4;  // std rp,-16(sp)

    // Instruction encodings: mask / match pairs
    localparam logic [WORD_W-1:0] LDO_MASK   = 32'hffffc001;
    localparam logic [WORD_W-1:0] LDO_MATCH  = 32'h37de0000;
    localparam logic [WORD_W-1:0] STWM_MASK  = 32'hffe00001;
    localparam logic [WORD_W-1:0] STWM_MATCH = 32'h6fc00000;
    localparam logic [WORD_W-1:0] STDMA_MASK = 32'hffe00009;
    localparam logic [WORD_W-1:0] STDMA_MATCH = 32'h73c00008;
    localparam logic [WORD_W-1:0] STW_RP_WORD = 32'h6bc23fd9;
    localparam logic [WORD_W-1:0] STD_RP_WORD = 32'h0fc212c1;

    // Return pointer slot offsets
    localparam logic [RP_W-1:0] RP_NONE    = 5'd0;
    localparam logic [RP_W-1:0] RP_OFS_STW = 5'd20;
    localparam logic [RP_W-1:0] RP_OFS_STD = 5'd16;

    // Saturation value of the frame accumulator
    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    // Decoded instruction word
    typedef struct packed {
        logic [CLS_W-1:0] insn_cls;
        logic [AMT_W-1:0] amount;
    } t_insn_dec;

    // Result of one item
    typedef struct packed {
        logic [LIMIT_W-1:0] frame_bytes;
        logic [RP_W-1:0]    rp_slot;
        logic               scanning;
        logic [CLS_W-1:0]   insn_cls;
    } t_result;

endpackage

// File: hdl/pfs_insn_decode.sv
// ============================================================================
// pfs_insn_decode: prologue instruction pattern matcher
// Classifies one instruction word and extracts the stack allocation amount
// in bytes for the allocating encodings.
// ============================================================================
module pfs_insn_decode (
    input  logic [pfs_pkg::WORD_W-1:0] i_insn_word,
    output pfs_pkg::t_insn_dec         o_dec
);
    import pfs_pkg::*;

    // Match encodings in priority order
    always_comb begin
        o_dec.insn_cls = CLS_NONE;
        o_dec.amount   = '0;
        if (((i_insn_word & LDO_MASK) == LDO_MATCH) ||
            ((i_insn_word & STWM_MASK) == STWM_MATCH)) begin
            // low 14 bits shifted right by one
            o_dec.insn_cls = CLS_ALLOC;
            o_dec.amount   = i_insn_word[13:1];
        end else if ((i_insn_word & STDMA_MASK) == STDMA_MATCH) begin
            // 10-bit displacement field in doublewords
            o_dec.insn_cls = CLS_STD_MA;
            o_dec.amount   = {i_insn_word[13:4], 3'b000};
        end else if (i_insn_word == STW_RP_WORD) begin
            o_dec.insn_cls = CLS_STW_RP;
        end else if (i_insn_word == STD_RP_WORD) begin
            o_dec.insn_cls = CLS_STD_RP;
        end
    end

endmodule

// File: hdl/pfs_frame_state.sv
// ============================================================================
// pfs_frame_state: frame analysis state and per-item update
// Holds the accumulated frame size, the limit, the return pointer slot and
// the scan flags; computes the next state and the result of one item.
// ============================================================================
module pfs_frame_state (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_req_type,
    input  logic [pfs_pkg::UNITS_W-1:0] i_frame_limit_units,
    input  logic                        i_save_rp,
    input  logic                        i_before_ip,
    input  pfs_pkg::t_insn_dec          i_dec,
    output pfs_pkg::t_result            o_res
);
    import pfs_pkg::*;

    logic [ACC_W-1:0]   r_acc,    n_acc;
    logic [LIMIT_W-1:0] r_limit,  n_limit;
    logic [RP_W-1:0]    r_rp,     n_rp;
    logic               r_seek,   n_seek;
    logic               r_active, n_active;
    logic [CLS_W-1:0]   n_cls;
    logic               can_scan;
    logic [ACC_W:0]     sum;
    logic [ACC_W-1:0]   acc_sat;

    // Scan condition on the current state
    assign can_scan = r_active && ((r_acc < {1'b0, r_limit}) || r_seek);

    // Saturating accumulate
    assign sum     = {1'b0, r_acc} + (ACC_W+1)'(i_dec.amount);
    assign acc_sat = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];

    // Next state
    always_comb begin
        n_acc    = r_acc;
        n_limit  = r_limit;
        n_rp     = r_rp;
        n_seek   = r_seek;
        n_active = r_active;
        n_cls    = CLS_NONE;
        if (i_req_type == REQ_START) begin
            n_acc    = '0;
            n_limit  = {i_frame_limit_units, 3'b000};
            n_rp     = RP_NONE;
            n_seek   = i_save_rp;
            n_active = 1'b1;
        end else if (can_scan && i_before_ip) begin
            n_cls = i_dec.insn_cls;
            case (i_dec.insn_cls)
                CLS_ALLOC, CLS_STD_MA: begin
                    n_acc = acc_sat;
                end
                CLS_STW_RP: begin
                    n_rp   = RP_OFS_STW;
                    n_seek = 1'b0;
                end
                CLS_STD_RP: begin
                    n_rp   = RP_OFS_STD;
                    n_seek = 1'b0;
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
        end else begin
            // scan never resumes within this analysis
            n_active = 1'b0;
        end
    end

    // Result of the item from the updated state
    always_comb begin
        o_res.frame_bytes = (n_acc > {1'b0, n_limit}) ? n_limit : n_acc[LIMIT_W-1:0];
        o_res.rp_slot     = n_rp;
        o_res.scanning    = n_active && ((n_acc < {1'b0, n_limit}) || n_seek);
        o_res.insn_cls    = n_cls;
    end

    // Hold analysis state; advance on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_limit  <= '0;
            r_rp     <= RP_NONE;
            r_seek   <= 1'b0;
            r_active <= 1'b0;
        end else if (i_step) begin
            r_acc    <= n_acc;
            r_limit  <= n_limit;
            r_rp     <= n_rp;
            r_seek   <= n_seek;
            r_active <= n_active;
        end
    end

    a_rp_slot_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rp == RP_NONE) || (r_rp == RP_OFS_STW) || (r_rp == RP_OFS_STD))
        else $error("return pointer slot holds an illegal offset");

    a_size_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> (o_res.frame_bytes <= n_limit))
        else $error("reported frame size exceeds the limit");

    a_idle_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_req_type == REQ_INSN) && !r_active) |->
            (!o_res.scanning && (o_res.insn_cls == CLS_NONE)))
        else $error("instruction examined without an open analysis");

    a_rp_ends_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_req_type == REQ_INSN) &&
         ((n_cls == CLS_STW_RP) || (n_cls == CLS_STD_RP))) |=> !r_seek)
        else $error("return pointer store did not end the search");

endmodule

// File: hdl/prologue_frame_size_scanner_core.sv
// ============================================================================
// prologue_frame_size_scanner_core: prologue frame size scanner, top level
// Registers each item, matches it against the prologue encodings, updates
// the frame analysis and registers one result per item.
//
//   channel   direction  handshake           payload
//   -------   ---------  ------------------  --------------------------------
//   input     in         i_valid / o_ready   req_type, frame_limit_units,
//                                            save_rp, insn_word, before_ip
//   result    out        o_valid / i_ready   frame_bytes, rp_slot,
//                                            scanning, insn_class
//
// One item per cycle sustained while i_ready stays high; each item passes the
// input register, then the result register, before its result is shown.
// The rate rests on the combinational state update: decode, one
// saturating add and three compares against the limit per item.
// Reset (synchronous, active low) empties both registers and clears the
// analysis state; o_ready is high as soon as reset is released.
// While i_ready is low the result holds, one further item waits in the
// input register, and o_ready then drops.
// ============================================================================
module prologue_frame_size_scanner_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic [pfs_pkg::UNITS_W-1:0]   i_frame_limit_units,
    input  logic                          i_save_rp,
    input  logic [pfs_pkg::WORD_W-1:0]    i_insn_word,
    input  logic                          i_before_ip,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pfs_pkg::LIMIT_W-1:0]   o_frame_bytes,
    output logic [pfs_pkg::RP_W-1:0]      o_rp_slot,
    output logic                          o_scanning,
    output logic [pfs_pkg::CLS_W-1:0]     o_insn_class
);
    import pfs_pkg::*;

    logic               r_in_valid;
    logic               r_req_type;
    logic [UNITS_W-1:0] r_units;
    logic               r_save_rp;
    logic [WORD_W-1:0]  r_word;
    logic               r_before_ip;
    logic               r_out_valid;
    t_result            r_out_res;
    t_result            res;
    t_insn_dec          dec;
    logic               advance;
    logic               in_take;

    // Move an item into the result register when that register frees up
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req_type  <= i_req_type;
            r_units     <= i_frame_limit_units;
            r_save_rp   <= i_save_rp;
            r_word      <= i_insn_word;
            r_before_ip <= i_before_ip;
        end
    end

    // Classify the instruction word
    pfs_insn_decode u_decode (
        .i_insn_word (r_word),
        .o_dec       (dec)
    );

    // Update the frame analysis
    pfs_frame_state u_state (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_step              (advance),
        .i_req_type          (r_req_type),
        .i_frame_limit_units (r_units),
        .i_save_rp           (r_save_rp),
        .i_before_ip         (r_before_ip),
        .i_dec               (dec),
        .o_res               (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_frame_bytes = r_out_res.frame_bytes;
    assign o_rp_slot     = r_out_res.rp_slot;
    assign o_scanning    = r_out_res.scanning;
    assign o_insn_class  = r_out_res.insn_cls;

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("waiting item dropped from the input register");

    a_out_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_ready && !advance) |=> !r_out_valid)
        else $error("taken result shown again");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out_res)))
        else $error("waiting result changed before it was taken");

endmodule

// File: tb/prologue_frame_size_scanner_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// prologue_frame_size_scanner_core_tb: self-checking bench for the scanner
// A clocked driver feeds start and instruction items from a queue, and a
// clocked monitor compares every result against a frame predictor kept in
// the bench. Stimulus runs directed corner items, random prologue sequences
// with noise, a long prologue that runs past its limit while rp is sought,
// and random idling on both sides.
// ============================================================================
module prologue_frame_size_scanner_core_tb;
    import pfs_pkg::*;

    localparam int MAX_GAP        = 16;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int LONG_WORDS     = 48;
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        logic               req_type;
        logic [UNITS_W-1:0] limit_units;
        logic               save_rp;
        logic [WORD_W-1:0]  insn_word;
        logic               before_ip;
    } t_scan_item;

    // Clock, reset and block inputs, all known from time zero
    logic                 i_clk               = 1'b0;
    logic                 i_rst_n             = 1'b0;
    logic                 i_valid             = 1'b0;
    logic                 i_req_type          = 1'b0;
    logic [UNITS_W-1:0]   i_frame_limit_units = '0;
    logic                 i_save_rp           = 1'b0;
    logic [WORD_W-1:0]    i_insn_word         = '0;
    logic                 i_before_ip         = 1'b0;
    logic                 i_ready             = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic [LIMIT_W-1:0]   o_frame_bytes;
    logic [RP_W-1:0]      o_rp_slot;
    logic                 o_scanning;
    logic [CLS_W-1:0]     o_insn_class;

    // Item stream and predicted frame reports
    t_scan_item insn_stream_q[$];
    t_result    frame_reports_q[$];
    t_scan_item cur_item;
    t_result    want;

    // Predicted analysis state
    logic [ACC_W-1:0]   frame_acc = '0;
    logic [LIMIT_W-1:0] frame_lim = '0;
    logic [RP_W-1:0]    rp_slot   = RP_NONE;
    logic               seek_rp   = 1'b0;
    logic               scan_on   = 1'b0;

    // Idling knobs and counters
    int tx_max_gap    = MAX_GAP;
    int rx_max_gap    = MAX_GAP;
    int tx_gap        = 0;
    int rx_wait       = 0;
    int rx_draw       = 0;
    int rx_hold_asks  = 0;
    int rx_hold_taken = 0;
    int rx_hold_left  = 0;
    int n_sent        = 0;
    int n_checked     = 0;
    int n_errors      = 0;
    int n_acc_sat     = 0;
    int class_hits[0:7];

    prologue_frame_size_scanner_core DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_req_type          (i_req_type),
        .i_frame_limit_units (i_frame_limit_units),
        .i_save_rp           (i_save_rp),
        .i_insn_word         (i_insn_word),
        .i_before_ip         (i_before_ip),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_frame_bytes       (o_frame_bytes),
        .o_rp_slot           (o_rp_slot),
        .o_scanning          (o_scanning),
        .o_insn_class        (o_insn_class)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        foreach (class_hits[k]) class_hits[k] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------
    function automatic logic scan_open();
        return scan_on && (frame_acc < {1'b0, frame_lim} || seek_rp);
    endfunction

    // Add to the frame size, saturating at the accumulator maximum
    task automatic grow_frame(input logic [AMT_W-1:0] amt);
        logic [ACC_W:0] sum;
        sum = {1'b0, frame_acc} + (ACC_W+1)'(amt);
        if (sum > {1'b0, ACC_MAX}) begin
            frame_acc = ACC_MAX;
            n_acc_sat++;
        end else begin
            frame_acc = sum[ACC_W-1:0];
        end
    endtask

    task automatic track_frame(input t_scan_item it);
        logic [CLS_W-1:0] cls;
        t_result          rpt;
        cls = CLS_NONE;
        if (it.req_type == REQ_START) begin
            frame_acc = '0;
            frame_lim = {it.limit_units, 3'b000};
            rp_slot   = RP_NONE;
            seek_rp   = it.save_rp;
            scan_on   = 1'b1;
        end else if (scan_open() && it.before_ip) begin
            if ((it.insn_word & LDO_MASK) == LDO_MATCH ||
                (it.insn_word & STWM_MASK) == STWM_MATCH) begin
                grow_frame(it.insn_word[13:1]);
                cls = CLS_ALLOC;
            end else if ((it.insn_word & STDMA_MASK) == STDMA_MATCH) begin
                grow_frame({it.insn_word[13:4], 3'b000});
                cls = CLS_STD_MA;
            end else if (it.insn_word == STW_RP_WORD) begin
                rp_slot = RP_OFS_STW;
                seek_rp = 1'b0;
                cls     = CLS_STW_RP;
            end else if (it.insn_word == STD_RP_WORD) begin
                rp_slot = RP_OFS_STD;
                seek_rp = 1'b0;
                cls     = CLS_STD_RP;
            end
        end else begin
            // once a word is skipped the scan never resumes
            scan_on = 1'b0;
        end
        rpt.frame_bytes = (frame_acc > {1'b0, frame_lim}) ? frame_lim
                                                           : frame_acc[LIMIT_W-1:0];
        rpt.rp_slot     = rp_slot;
        rpt.scanning    = scan_open();
        rpt.insn_cls    = cls;
        class_hits[cls]++;
        frame_reports_q.push_back(rpt);
    endtask

    // ------------------------------------------------------------------
    // Item builders; fields an item type does not use get random values
    // ------------------------------------------------------------------
    function automatic t_scan_item mk_start(logic [UNITS_W-1:0] units, logic save);
        t_scan_item it;
        it.req_type    = REQ_START;
        it.limit_units = units;
        it.save_rp     = save;
        it.insn_word   = $urandom;
        it.before_ip   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_scan_item mk_insn(logic [WORD_W-1:0] word, logic below_pc);
        t_scan_item it;
        it.req_type    = REQ_INSN;
        it.limit_units = UNITS_W'($urandom);
        it.save_rp     = 1'($urandom_range(0, 1));
        it.insn_word   = word;
        it.before_ip   = below_pc;
        return it;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 9))
            0, 1:    w = LDO_MATCH | ($urandom & ~LDO_MASK);
            2:       w = STWM_MATCH | ($urandom & ~STWM_MASK);
            3, 4:    w = STDMA_MATCH | ($urandom & ~STDMA_MASK);
            5:       w = STW_RP_WORD;
            6:       w = STD_RP_WORD;
            // near misses: one bit away from a pattern
            7:       w = LDO_MATCH ^ (32'd1 << $urandom_range(0, 31));
            8:       w = ($urandom_range(0, 1) ? STW_RP_WORD : STDMA_MATCH)
                         ^ (32'd1 << $urandom_range(0, 31));
            default: w = $urandom;
        endcase
        return w;
    endfunction

    function automatic int draw_gap(int mx);
        if (mx == 0 || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, mx);
    endfunction

    task automatic report_miss(input string fld, input int unsigned expd,
                               input int unsigned got);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, expd, got);
    endtask

    // ------------------------------------------------------------------
    // Driver: hold each item until accepted, then idle before the next
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (i_valid && o_ready) begin
                track_frame(cur_item);
                n_sent++;
            end
            if (!i_valid || o_ready) begin
                if (tx_gap != 0) begin
                    tx_gap  <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (insn_stream_q.size() != 0) begin
                    cur_item            = insn_stream_q.pop_front();
                    i_req_type          <= cur_item.req_type;
                    i_frame_limit_units <= cur_item.limit_units;
                    i_save_rp           <= cur_item.save_rp;
                    i_insn_word         <= cur_item.insn_word;
                    i_before_ip         <= cur_item.before_ip;
                    i_valid             <= 1'b1;
                    tx_gap              <= draw_gap(tx_max_gap);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result, then stall for a random count
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (frame_reports_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: stray result, expected none, actual size %0d class %0d",
                                 $time, o_frame_bytes, o_insn_class);
                end else begin
                    want = frame_reports_q.pop_front();
                    n_checked++;
                    if (o_frame_bytes !== want.frame_bytes)
                        report_miss("frame_bytes", 32'(want.frame_bytes), 32'(o_frame_bytes));
                    if (o_rp_slot !== want.rp_slot)
                        report_miss("rp_slot", 32'(want.rp_slot), 32'(o_rp_slot));
                    if (o_scanning !== want.scanning)
                        report_miss("scanning", 32'(want.scanning), 32'(o_scanning));
                    if (o_insn_class !== want.insn_cls)
                        report_miss("insn_class", 32'(want.insn_cls), 32'(o_insn_class));
                end
            end
            if (rx_hold_left != 0) begin
                rx_hold_left <= rx_hold_left - 1;
                i_ready      <= 1'b0;
            end else if (rx_hold_asks != rx_hold_taken) begin
                rx_hold_taken <= rx_hold_asks;
                rx_hold_left  <= RX_HOLD_CYCLES;
                i_ready       <= 1'b0;
            end else if (o_valid && i_ready) begin
                rx_draw = draw_gap(rx_max_gap);
                rx_wait <= rx_draw;
                i_ready <= (rx_draw == 0);
            end else if (rx_wait != 0) begin
                rx_wait <= rx_wait - 1;
                i_ready <= (rx_wait == 1);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Wait until every item is sent and every result is back
    task automatic wait_drained();
        while (insn_stream_q.size() != 0 || i_valid || frame_reports_q.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [UNITS_W-1:0] units;
        int                 n_queued;
        int                 len;
        int                 stretch;
        bit                 paused;
        bit                 held;
        n_queued = 0;
        paused   = 1'b0;
        held     = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);

        // instruction before any start: leaves the reset state
        insn_stream_q.push_back(mk_insn(STW_RP_WORD, 1'b1));
        // empty frame with nothing sought: the first word is skipped
        insn_stream_q.push_back(mk_start('0, 1'b0));
        insn_stream_q.push_back(mk_insn(LDO_MATCH | 32'h2, 1'b1));
        // largest limit, every pattern at its extremes
        insn_stream_q.push_back(mk_start('1, 1'b1));
        insn_stream_q.push_back(mk_insn(LDO_MATCH | ~LDO_MASK, 1'b1));
        insn_stream_q.push_back(mk_insn(STWM_MATCH | ~STWM_MASK, 1'b1));
        insn_stream_q.push_back(mk_insn(STDMA_MATCH | ~STDMA_MASK, 1'b1));
        insn_stream_q.push_back(mk_insn(STDMA_MATCH, 1'b1));
        insn_stream_q.push_back(mk_insn(STW_RP_WORD, 1'b1));
        // rp store after the search is over still moves the slot
        insn_stream_q.push_back(mk_insn(STD_RP_WORD, 1'b1));
        // word at the pc ends the scan for good
        insn_stream_q.push_back(mk_insn(LDO_MATCH | 32'h10, 1'b0));
        insn_stream_q.push_back(mk_insn(STD_RP_WORD, 1'b1));
        // size runs past the limit: clamp, then stop
        insn_stream_q.push_back(mk_start(27'd1, 1'b0));
        insn_stream_q.push_back(mk_insn(LDO_MATCH | 32'hc8, 1'b1));
        insn_stream_q.push_back(mk_insn(LDO_MATCH | 32'h2, 1'b1));
        // past the limit but still seeking rp
        insn_stream_q.push_back(mk_start(27'd2, 1'b1));
        insn_stream_q.push_back(mk_insn(STWM_MATCH | 32'h3ffe, 1'b1));
        insn_stream_q.push_back(mk_insn(LDO_MATCH | 32'h1, 1'b1));
        insn_stream_q.push_back(mk_insn(STD_RP_WORD, 1'b1));
        // odd words inside a small frame
        insn_stream_q.push_back(mk_start(27'd5, 1'b0));
        insn_stream_q.push_back(mk_insn('1, 1'b1));
        insn_stream_q.push_back(mk_insn('0, 1'b1));
        insn_stream_q.push_back(mk_insn(STW_RP_WORD ^ 32'h1, 1'b1));
        insn_stream_q.push_back(mk_insn(STW_RP_WORD, 1'b0));
        wait_drained();

        // random prologues, mostly well formed, with some noise
        while (n_queued < RANDOM_ITEMS) begin
            if (!paused && n_queued >= RANDOM_ITEMS / 4) begin
                paused = 1'b1;
                wait_drained();
            end
            stretch = (n_queued / 200) % 3;
            rx_max_gap = (stretch == 1) ? 0 : MAX_GAP;
            if (n_queued >= RANDOM_ITEMS / 2 && n_queued < RANDOM_ITEMS / 2 + 80) begin
                // keep offering items while the receiver holds off
                tx_max_gap = 0;
                if (!held) begin
                    held = 1'b1;
                    rx_hold_asks++;
                end
            end else begin
                tx_max_gap = (stretch == 1) ? 0 : MAX_GAP;
            end

            if ($urandom_range(0, 99) < 85) begin
                case ($urandom_range(0, 5))
                    0:       units = '0;
                    1:       units = UNITS_W'($urandom_range(1, 64));
                    2:       units = UNITS_W'($urandom_range(1, 4096));
                    3:       units = UNITS_W'($urandom);
                    4:       units = '1;
                    default: units = UNITS_W'($urandom_range(65, 2_000_000));
                endcase
                insn_stream_q.push_back(mk_start(units, 1'($urandom_range(0, 1))));
                len = $urandom_range(2, 24);
                repeat (len)
                    insn_stream_q.push_back(mk_insn(pick_word(), $urandom_range(0, 19) != 0));
                n_queued += len + 1;
            end else begin
                len = $urandom_range(1, 4);
                repeat (len) begin
                    if ($urandom_range(0, 1))
                        insn_stream_q.push_back(mk_start(UNITS_W'($urandom),
                                                         1'($urandom_range(0, 1))));
                    else
                        insn_stream_q.push_back(mk_insn($urandom_range(0, 1) ? pick_word()
                                                                             : $urandom,
                                                        1'($urandom_range(0, 1))));
                end
                n_queued += len;
            end
            while (insn_stream_q.size() > 8) @(negedge i_clk);
        end

        // one long prologue back to back, past its limit while rp is sought
        wait_drained();
        tx_max_gap = 0;
        rx_max_gap = 0;
        insn_stream_q.push_back(mk_start(27'd4096, 1'b1));
        for (int k = 0; k < LONG_WORDS; k++) begin
            insn_stream_q.push_back(mk_insn(STDMA_MATCH | ~STDMA_MASK, 1'b1));
        end
        insn_stream_q.push_back(mk_insn(STD_RP_WORD, 1'b1));
        insn_stream_q.push_back(mk_insn(LDO_MATCH | ~LDO_MASK, 1'b1));

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Run covered %0d items and %0d checked results, %0d saturating adds.",
                 n_sent, n_checked, n_acc_sat);
        $display("Classes seen: ignored %0d, ldo/stwm %0d, std,ma %0d, stw rp %0d, std rp %0d.",
                 class_hits[CLS_NONE], class_hits[CLS_ALLOC], class_hits[CLS_STD_MA],
                 class_hits[CLS_STW_RP], class_hits[CLS_STD_RP]);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #30_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, frame_reports_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
